[rtl/core/imh_pkg.sv]
// imh_pkg: request and result types, action and status codes and sequencer
// states of the indexed min-heap unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;

  localparam int ID_BITS   = 8;
  localparam int ID_COUNT  = 256;
  localparam int CNT_BITS  = 9;
  localparam int DIST_BITS = 32;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DEL_MIN  = 2'd1,
    ACT_DECREASE = 2'd2,
    ACT_NONE     = 2'd3
  } imh_action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_NOT_PRESENT = 3'd3,
    ST_NOT_DEC     = 3'd4,
    ST_DUPLICATE   = 3'd5
  } imh_status_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [ID_BITS-1:0]   node_id;
    logic [DIST_BITS-1:0] distance;
  } imh_in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ID_BITS-1:0]   min_node;
    logic [DIST_BITS-1:0] min_distance;
    logic                 heap_empty;
    logic [CNT_BITS-1:0]  entry_total;
  } imh_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS_WAIT,
    S_KEY_WAIT,
    S_UP_RD,
    S_UP_CMP,
    S_LAST_WAIT,
    S_DN_RD,
    S_DN_L,
    S_DN_R,
    S_DONE
  } imh_state_t;

endpackage
`default_nettype wire

[rtl/core/imh_ram.sv]
// imh_ram: simple dual-port synchronous memory, one write and one read port,
// registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/imh_seq.sv]
// imh_seq: request sequencer of the min-heap; walks sift-up and sift-down over
// the heap and position memories. Depends on imh_pkg and imh_ram.
`timescale 1ns / 1ps
`default_nettype none
module imh_seq #(
  parameter int MAX_ENTRIES = 256,
  parameter int KEY_BITS    = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire imh_pkg::imh_in_t         in_req,
  input  wire logic [imh_pkg::CNT_BITS-1:0] cap,
  output logic                          out_valid,
  output imh_pkg::imh_out_t             out_res
);
  import imh_pkg::*;

  localparam int SW = $clog2(MAX_ENTRIES);
  localparam int XW = (SW + 1 > CNT_BITS) ? SW + 1 : CNT_BITS;
  localparam int HW = ID_BITS + KEY_BITS;

  // memory ports
  logic          h_we;
  logic [SW-1:0] h_waddr, h_raddr;
  logic [HW-1:0] h_wdata, h_rdata;
  logic          p_we;
  logic [ID_BITS-1:0] p_waddr, p_raddr;
  logic [SW-1:0] p_wdata, p_rdata;

  imh_ram #(.WIDTH(HW), .DEPTH(MAX_ENTRIES)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  imh_ram #(.WIDTH(SW), .DEPTH(ID_COUNT)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  imh_state_t          state_r, state_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [ID_COUNT-1:0] present_r, present_nxt;
  logic [SW-1:0]       idx_r, idx_nxt;
  logic [ID_BITS-1:0]  cur_id_r, cur_id_nxt;
  logic [KEY_BITS-1:0] cur_key_r, cur_key_nxt;
  logic [ID_BITS-1:0]  root_id_r;
  logic [KEY_BITS-1:0] root_key_r;
  logic [2:0]          status_r, status_nxt;
  logic [HW-1:0]       left_r, left_nxt;
  logic                left_win_r, left_win_nxt;
  logic                out_valid_r;
  imh_out_t            out_res_r;

  // derived indices and keys
  logic [XW-1:0]       cnt_x, cap_x, eff_cap, left_x, right_x, par_x;
  logic [KEY_BITS-1:0] in_key, rd_key, left_key, best_key;
  logic [ID_BITS-1:0]  rd_id;

  assign cnt_x   = XW'(count_r);
  assign cap_x   = XW'(cap);
  assign eff_cap = (cap_x > XW'(MAX_ENTRIES)) ? XW'(MAX_ENTRIES) : cap_x;
  assign left_x  = XW'({idx_r, 1'b0}) + XW'(1);
  assign right_x = left_x + XW'(1);
  assign par_x   = (XW'(idx_r) - XW'(1)) >> 1;
  assign in_key  = KEY_BITS'(in_req.distance);
  assign rd_id   = h_rdata[HW-1 -: ID_BITS];
  assign rd_key  = h_rdata[KEY_BITS-1:0];
  assign left_key = left_r[KEY_BITS-1:0];
  assign best_key = left_win_r ? left_key : cur_key_r;

  // state and data registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cur_id_r   <= cur_id_nxt;
    cur_key_r  <= cur_key_nxt;
    status_r   <= status_nxt;
    left_r     <= left_nxt;
    left_win_r <= left_win_nxt;
    if (h_we && h_waddr == '0) begin
      root_id_r  <= h_wdata[HW-1 -: ID_BITS];
      root_key_r <= h_wdata[KEY_BITS-1:0];
    end
    if (state_r == S_DONE) begin
      out_res_r.status       <= status_r;
      out_res_r.min_node     <= (count_r != '0) ? root_id_r : '0;
      out_res_r.min_distance <= (count_r != '0) ? DIST_BITS'(root_key_r) : '0;
      out_res_r.heap_empty   <= (count_r == '0);
      out_res_r.entry_total  <= count_r;
    end
  end

  // next state and memory requests
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    present_nxt  = present_r;
    idx_nxt      = idx_r;
    cur_id_nxt   = cur_id_r;
    cur_key_nxt  = cur_key_r;
    status_nxt   = status_r;
    left_nxt     = left_r;
    left_win_nxt = left_win_r;
    h_we    = 1'b0;
    h_waddr = idx_r;
    h_wdata = {cur_id_r, cur_key_r};
    h_raddr = idx_r;
    p_we    = 1'b0;
    p_waddr = cur_id_r;
    p_wdata = idx_r;
    p_raddr = in_req.node_id;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt  = ST_OK;
          cur_id_nxt  = in_req.node_id;
          cur_key_nxt = in_key;
          state_nxt   = S_DONE;
          unique case (in_req.action)
            ACT_INSERT: begin
              if (present_r[in_req.node_id]) begin
                status_nxt = ST_DUPLICATE;
              end else if (cnt_x >= eff_cap) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = SW'(count_r);
                count_nxt = count_r + CNT_BITS'(1);
                present_nxt[in_req.node_id] = 1'b1;
                state_nxt = S_UP_RD;
              end
            end
            ACT_DEL_MIN: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                present_nxt[root_id_r] = 1'b0;
                count_nxt = count_r - CNT_BITS'(1);
                h_raddr   = SW'(count_r - CNT_BITS'(1));
                if (count_r != CNT_BITS'(1)) begin
                  state_nxt = S_LAST_WAIT;
                end
              end
            end
            ACT_DECREASE: begin
              if (!present_r[in_req.node_id]) begin
                status_nxt = ST_NOT_PRESENT;
              end else begin
                state_nxt = S_POS_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_POS_WAIT: begin
        idx_nxt = p_rdata;
        h_raddr = p_rdata;
        if (XW'(p_rdata) >= cnt_x) begin
          status_nxt = ST_NOT_PRESENT;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_KEY_WAIT;
        end
      end
      S_KEY_WAIT: begin
        if (cur_key_r > rd_key) begin
          status_nxt = ST_NOT_DEC;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      // sift up: fetch the parent, or place the entry at the root
      S_UP_RD: begin
        if (idx_r == '0) begin
          h_we = 1'b1;
          p_we = 1'b1;
          state_nxt = S_DONE;
        end else begin
          h_raddr   = SW'(par_x);
          state_nxt = S_UP_CMP;
        end
      end
      // move parent down or place the entry
      S_UP_CMP: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (cur_key_r < rd_key) begin
          h_wdata   = h_rdata;
          p_waddr   = rd_id;
          idx_nxt   = SW'(par_x);
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LAST_WAIT: begin
        cur_id_nxt  = rd_id;
        cur_key_nxt = rd_key;
        idx_nxt     = '0;
        state_nxt   = S_DN_RD;
      end
      // sift down: fetch the left child, or place the entry at a leaf
      S_DN_RD: begin
        if (left_x >= cnt_x) begin
          h_we = 1'b1;
          p_we = 1'b1;
          state_nxt = S_DONE;
        end else begin
          h_raddr   = SW'(left_x);
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        left_nxt     = h_rdata;
        left_win_nxt = (rd_key < cur_key_r);
        if (right_x < cnt_x) begin
          h_raddr   = SW'(right_x);
          state_nxt = S_DN_R;
        end else begin
          h_we = 1'b1;
          p_we = 1'b1;
          if (rd_key < cur_key_r) begin
            h_wdata   = h_rdata;
            p_waddr   = rd_id;
            idx_nxt   = SW'(left_x);
            state_nxt = S_DN_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      // right child known: pick the smallest of three
      S_DN_R: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (rd_key < best_key) begin
          h_wdata   = h_rdata;
          p_waddr   = rd_id;
          idx_nxt   = SW'(right_x);
          state_nxt = S_DN_RD;
        end else if (left_win_r) begin
          h_wdata   = left_r;
          p_waddr   = left_r[HW-1 -: ID_BITS];
          idx_nxt   = SW'(left_x);
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

[rtl/core/indexed_min_heap_unit.sv]
// indexed_min_heap_unit: top level of the indexed binary min-heap with
// decrease-key; holds the capacity register. Depends on imh_pkg and imh_seq.
//
// Usage: a request (action, node_id, distance) is taken at a rising edge
// where start is high and busy is low. Insert places an id with its key,
// delete-min drops the root, decrease lowers the key of a present id.
// Each request gives one result, shown on out_res for exactly one cycle
// while out_valid is high: status, root entry, empty flag and count after
// the request. The receiver cannot stall; results are never held.
// A request that is invalid at once goes straight to its result; a decrease
// first reads the position and then the key of its id, and is rejected if
// it would raise the key. Insert and decrease then climb the heap, with one
// parent read and one compare/write per level; delete-min reads the last
// entry and descends, with up to two child reads per level.
// The single read port of the heap memory sets this pacing; one request
// is in flight at a time and busy stays high until its result is formed.
// The capacity register is written on cfg_valid (cfg_ready is always high)
// and should change only while idle. Reset empties the heap and sets the
// capacity to 256; heap and position memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_unit #(
  parameter int MAX_ENTRIES = 256,
  parameter int KEY_BITS    = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire imh_pkg::imh_in_t         in_req,
  output logic                          out_valid,
  output imh_pkg::imh_out_t             out_res,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [imh_pkg::CNT_BITS-1:0] cfg_data
);
  import imh_pkg::*;

  logic [CNT_BITS-1:0] cap_r;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_BITS'(256);
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  imh_seq #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .cap(cap_r), .out_valid(out_valid), .out_res(out_res)
  );

endmodule
`default_nettype wire
